### hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/met_pkg.sv
package met_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 28;
    localparam int IMAGE_SIZE = 1024;
    localparam int PIX_W      = $clog2(IMAGE_SIZE);
    localparam int PIXC_W     = PIX_W + 1;
    localparam int STEP_W     = 29;
    localparam int LIMIT_W    = 16;
    localparam int NUM_CELLS  = 2;

    localparam int SQ_W    = 2 * DATA_W - FRAC_BITS - 1;
    localparam int SQS_W   = SQ_W + 1;
    localparam int XY_W    = 2 * DATA_W - FRAC_BITS + 1;
    localparam int SUM_W   = XY_W + 1;
    localparam int PROD_W  = STEP_W + PIX_W;
    localparam int CSUM_W  = PROD_W + 2;

    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam int PDATA_W   = 32;

    localparam logic [SQS_W-1:0] FOUR_Q = SQS_W'(64'd4 << FRAC_BITS);
    localparam logic signed [CSUM_W-1:0] TWO_C = CSUM_W'(64'sd2 <<< FRAC_BITS);
    localparam logic signed [CSUM_W-1:0] NEG_TWO_C = -TWO_C;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(976129);
    localparam logic signed [DATA_W-1:0] ORIGIN_RE_RESET = 32'hE000_0000;
    localparam logic signed [DATA_W-1:0] ORIGIN_IM_RESET = 32'hEB33_3333;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    typedef enum logic [1:0] {
        ST_SKIPPED = 2'd0,
        ST_ESCAPED = 2'd1,
        ST_INSIDE  = 2'd2
    } point_status_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_STEP_SIZE  = 2'd0,
        REG_ORIGIN_RE  = 2'd1,
        REG_ORIGIN_IM  = 2'd2,
        REG_ITER_LIMIT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_W-1:0]         step;
        logic signed [DATA_W-1:0]  origin_re;
        logic signed [DATA_W-1:0]  origin_im;
        logic [LIMIT_W-1:0]        limit;
    } cfg_t;

    // status, count, squares and doubled cross product of the current z, as handed between cells
    typedef struct packed {
        logic                     done;
        point_status_t            status;
        logic [LIMIT_W-1:0]       count;
        logic [SQ_W-1:0]          sx;
        logic [SQ_W-1:0]          sy;
        logic signed [XY_W-1:0]   pxy;
    } iter_data_t;

    typedef struct packed {
        logic       valid;
        iter_data_t data;
    } ring_pkt_t;

    typedef struct packed {
        logic                      done;
        point_status_t             status;
        logic [LIMIT_W-1:0]        count;
        logic signed [DATA_W-1:0]  zx;
        logic signed [DATA_W-1:0]  zy;
    } z_data_t;

    function automatic logic signed [DATA_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (!v[SUM_W-1] && (|v[SUM_W-2:DATA_W-1]))
            r = {1'b0, {(DATA_W-1){1'b1}}};
        else if (v[SUM_W-1] && !(&v[SUM_W-2:DATA_W-1]))
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

### hdl/met_cfg.sv
module met_cfg
    import met_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    cfg_reg_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step      <= STEP_RESET;
            cfg_reg.origin_re <= ORIGIN_RE_RESET;
            cfg_reg.origin_im <= ORIGIN_IM_RESET;
            cfg_reg.limit     <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_STEP_SIZE:  cfg_reg.step      <= pwdata[STEP_W-1:0];
                REG_ORIGIN_RE:  cfg_reg.origin_re <= pwdata[DATA_W-1:0];
                REG_ORIGIN_IM:  cfg_reg.origin_im <= pwdata[DATA_W-1:0];
                REG_ITER_LIMIT: cfg_reg.limit     <= pwdata[LIMIT_W-1:0];
                default:        cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_STEP_SIZE:  prdata = PDATA_W'(cfg_reg.step);
            REG_ORIGIN_RE:  prdata = cfg_reg.origin_re;
            REG_ORIGIN_IM:  prdata = cfg_reg.origin_im;
            REG_ITER_LIMIT: prdata = PDATA_W'(cfg_reg.limit);
            default:        prdata = '0;
        endcase
    end

endmodule

### hdl/met_cell.sv
module met_cell
    import met_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [DATA_W-1:0] c_re,
    input  logic signed [DATA_W-1:0] c_im,
    input  logic [LIMIT_W-1:0]       limit,
    input  ring_pkt_t                pkt_in,
    output ring_pkt_t                pkt_out
);

    logic                       a_valid_reg;
    z_data_t                    a_reg;
    z_data_t                    a_next;
    logic                       m_valid_reg;
    iter_data_t                 m_reg;
    iter_data_t                 m_next;

    logic [SQS_W-1:0]           mag_sum;
    logic                       escaped;
    logic signed [SUM_W-1:0]    nx_sum;
    logic signed [SUM_W-1:0]    ny_sum;
    logic signed [DATA_W-1:0]   zx;
    logic signed [DATA_W-1:0]   zy;
    logic signed [2*DATA_W-1:0] pxx;
    logic signed [2*DATA_W-1:0] pyy;
    logic signed [2*DATA_W-1:0] pxy_full;

    // add stage: escape test on the incoming squares, then the next z
    assign mag_sum = {1'b0, pkt_in.data.sx} + {1'b0, pkt_in.data.sy};
    assign escaped = mag_sum > FOUR_Q;
    assign nx_sum  = SUM_W'($signed({1'b0, pkt_in.data.sx}))
                   - SUM_W'($signed({1'b0, pkt_in.data.sy}))
                   + SUM_W'(c_re);
    assign ny_sum  = SUM_W'($signed(pkt_in.data.pxy)) + SUM_W'(c_im);

    always_comb
    begin
        a_next.done   = pkt_in.data.done;
        a_next.status = pkt_in.data.status;
        a_next.count  = pkt_in.data.count;
        a_next.zx     = sat_z(nx_sum);
        a_next.zy     = sat_z(ny_sum);
        if (!pkt_in.data.done)
        begin
            if (escaped)
            begin
                a_next.done   = 1'b1;
                a_next.status = ST_ESCAPED;
                a_next.count  = pkt_in.data.count - LIMIT_W'(1);
            end
            else if (pkt_in.data.count >= limit)
            begin
                a_next.done   = 1'b1;
                a_next.status = (pkt_in.data.count == limit) ? ST_INSIDE : ST_ESCAPED;
            end
            else
            begin
                a_next.count = pkt_in.data.count + LIMIT_W'(1);
            end
        end
    end

    // multiply stage
    assign zx       = a_reg.zx;
    assign zy       = a_reg.zy;
    assign pxx      = zx * zx;
    assign pyy      = zy * zy;
    assign pxy_full = zx * zy;

    always_comb
    begin
        m_next.done   = a_reg.done;
        m_next.status = a_reg.status;
        m_next.count  = a_reg.count;
        m_next.sx     = pxx[2*DATA_W-2:FRAC_BITS];
        m_next.sy     = pyy[2*DATA_W-2:FRAC_BITS];
        m_next.pxy    = pxy_full[2*DATA_W-1:FRAC_BITS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= pkt_in.valid;
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        m_reg <= m_next;
    end

    assign pkt_out.valid = m_valid_reg;
    assign pkt_out.data  = m_reg;

endmodule

### hdl/mandelbrot_escape_time_unit.sv
// one item at a time: in_stall is high from accept until the result is registered
// the next item can be accepted in the cycle after the result is registered
// each iteration passes through one ring cell: one add stage, one multiply stage
// rst_n is asynchronous, active low: clears control and restores the register defaults
`include "assert_macros.svh"

module mandelbrot_escape_time_unit
    import met_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PIX_W-1:0]   pixel_col,
    input  logic [PIX_W-1:0]   pixel_row,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         point_status,
    output logic [LIMIT_W-1:0] escape_count,
    output logic [PIX_W-1:0]   out_col,
    output logic [PIX_W-1:0]   out_row
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAP  = 5'b00010,
        S_CMP  = 5'b00100,
        S_INJ  = 5'b01000,
        S_RUN  = 5'b10000
    } state_t;

    cfg_t                      cfg;
    state_t                    state_reg;
    state_t                    state_next;

    logic [PIX_W-1:0]          col_reg;
    logic [PIX_W-1:0]          row_reg;
    logic [PROD_W-1:0]         prod_re_reg;
    logic [PROD_W-1:0]         prod_im_reg;
    logic signed [DATA_W-1:0]  cre_reg;
    logic signed [DATA_W-1:0]  cim_reg;
    logic                      inwin_reg;

    logic signed [CSUM_W-1:0]  cre_sum;
    logic signed [CSUM_W-1:0]  cim_sum;
    logic                      in_win;

    logic                      out_valid_reg;
    point_status_t             out_status_reg;
    logic [LIMIT_W-1:0]        out_count_reg;
    logic [PIX_W-1:0]          out_col_reg;
    logic [PIX_W-1:0]          out_row_reg;

    ring_pkt_t                 inj_pkt;
    ring_pkt_t                 ring_in;
    ring_pkt_t                 ring_out;
    ring_pkt_t                 cell_out [NUM_CELLS];
    logic [NUM_CELLS-1:0]      ring_valid;
    logic                      in_take;
    logic                      capture;

    met_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    // map the pixel to c and apply the window
    assign cre_sum = CSUM_W'($signed(cfg.origin_re)) + $signed(CSUM_W'(prod_re_reg));
    assign cim_sum = CSUM_W'($signed(cfg.origin_im)) + $signed(CSUM_W'(prod_im_reg));
    assign in_win  = ({1'b0, col_reg} < PIXC_W'(IMAGE_SIZE))
                  && ({1'b0, row_reg} < PIXC_W'(IMAGE_SIZE))
                  && (cre_sum >= NEG_TWO_C) && (cre_sum <= TWO_C)
                  && (cim_sum >= NEG_TWO_C) && (cim_sum <= TWO_C);

    always_comb
    begin
        inj_pkt.valid       = 1'b1;
        inj_pkt.data.done   = !inwin_reg;
        inj_pkt.data.status = ST_SKIPPED;
        inj_pkt.data.count  = inwin_reg ? LIMIT_W'(1) : '0;
        inj_pkt.data.sx     = '0;
        inj_pkt.data.sy     = '0;
        inj_pkt.data.pxy    = '0;
    end

    // ring of cells; a finished item keeps circulating until the output register is free
    assign ring_out = cell_out[NUM_CELLS-1];
    assign capture  = (state_reg == S_RUN) && ring_out.valid && ring_out.data.done
                   && (!out_valid_reg || !out_stall);

    always_comb
    begin
        ring_in       = ring_out;
        ring_in.valid = ring_out.valid && !capture;
        if (state_reg == S_INJ)
            ring_in = inj_pkt;
    end

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        ring_pkt_t cell_in;
        if (k == 0)
        begin : g_head
            assign cell_in = ring_in;
        end
        else
        begin : g_link
            assign cell_in = cell_out[k-1];
        end

        met_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .c_re    (cre_reg),
            .c_im    (cim_reg),
            .limit   (cfg.limit),
            .pkt_in  (cell_in),
            .pkt_out (cell_out[k])
        );

        assign ring_valid[k] = cell_out[k].valid;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_take) state_next = S_MAP;
            S_MAP:   state_next = S_CMP;
            S_CMP:   state_next = S_INJ;
            S_INJ:   state_next = S_RUN;
            S_RUN:   if (capture) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (capture)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            col_reg <= pixel_col;
            row_reg <= pixel_row;
        end
        if (state_reg == S_MAP)
        begin
            prod_re_reg <= PROD_W'(col_reg) * PROD_W'(cfg.step);
            prod_im_reg <= PROD_W'(row_reg) * PROD_W'(cfg.step);
        end
        if (state_reg == S_CMP)
        begin
            cre_reg   <= cre_sum[DATA_W-1:0];
            cim_reg   <= cim_sum[DATA_W-1:0];
            inwin_reg <= in_win;
        end
        if (capture)
        begin
            out_status_reg <= ring_out.data.status;
            out_count_reg  <= ring_out.data.count;
            out_col_reg    <= col_reg;
            out_row_reg    <= row_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_status = out_status_reg;
    assign escape_count = out_count_reg;
    assign out_col      = out_col_reg;
    assign out_row      = out_row_reg;

    `ASSERT_IMPLIES(a_single_item, clk, rst_n, 1'b1, $countones(ring_valid) <= 1, "more than one item in the ring")
    `ASSERT_IMPLIES(a_idle_empty, clk, rst_n, state_reg == S_IDLE, ring_valid == '0, "ring busy while idle")
    `ASSERT_IMPLIES(a_skip_count, clk, rst_n, out_valid_reg && (out_status_reg == ST_SKIPPED), out_count_reg == '0, "skipped item with nonzero count")
    `ASSERT_IMPLIES(a_result_src, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_RUN), "result without a running item")
    `ASSERT_NEXT(a_capture_idle, clk, rst_n, capture, out_valid_reg && (state_reg == S_IDLE), "capture did not free the ring")

endmodule

### verif/mandelbrot_escape_time_unit_tb.sv
module mandelbrot_escape_time_unit_tb
    import met_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 400000;

    typedef struct {
        point_status_t      status;
        logic [LIMIT_W-1:0] count;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
    } pixel_result_t;

    class pixel_ledger;
        logic [STEP_W-1:0]        step;
        logic signed [DATA_W-1:0] re0;
        logic signed [DATA_W-1:0] im0;
        logic [LIMIT_W-1:0]       limit;
        pixel_result_t            awaited[$];
        int                       mismatches;

        function new();
            step = STEP_RESET;
            re0 = ORIGIN_RE_RESET;
            im0 = ORIGIN_IM_RESET;
            limit = LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [PDATA_W-1:0] v);
            case (idx)
                REG_STEP_SIZE:  step = v[STEP_W-1:0];
                REG_ORIGIN_RE:  re0 = v;
                REG_ORIGIN_IM:  im0 = v;
                REG_ITER_LIMIT: limit = v[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > longint'(32'sh7FFF_FFFF))
                return longint'(32'sh7FFF_FFFF);
            if (v < -longint'(64'sh8000_0000))
                return -longint'(64'sh8000_0000);
            return v;
        endfunction

        function pixel_result_t escape_time_of(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
            pixel_result_t r;
            longint two;
            longint four;
            longint cre;
            longint cim;
            longint zx;
            longint zy;
            longint nx;
            longint ny;
            int i;
            two = longint'(2) <<< FRAC_BITS;
            four = longint'(4) <<< FRAC_BITS;
            cre = longint'(re0) + longint'(col) * longint'(step);
            cim = longint'(im0) + longint'(row) * longint'(step);
            r.status = ST_SKIPPED;
            r.count = '0;
            r.col = col;
            r.row = row;
            if (cre >= -two && cre <= two && cim >= -two && cim <= two)
            begin
                zx = 0;
                zy = 0;
                i = 1;
                while (i < int'(limit))
                begin
                    nx = clamp32(((zx * zx) >>> FRAC_BITS) - ((zy * zy) >>> FRAC_BITS) + cre);
                    ny = clamp32(((zx * zy) >>> (FRAC_BITS - 1)) + cim);
                    zx = nx;
                    zy = ny;
                    if (((zx * zx) >>> FRAC_BITS) + ((zy * zy) >>> FRAC_BITS) > four)
                        break;
                    i++;
                end
                r.status = (i == int'(limit)) ? ST_INSIDE : ST_ESCAPED;
                r.count = LIMIT_W'(i);
            end
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
            awaited.push_back(escape_time_of(col, row));
        endfunction

        function void check_pixel(logic [1:0] st, logic [LIMIT_W-1:0] cnt,
                                  logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
            pixel_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d count %0d col %0d row %0d",
                             st, cnt, col, row);
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status || cnt !== want.count || col !== want.col
                || row !== want.row)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d count %0d col %0d row %0d, %s",
                             want.status, want.count, want.col, want.row,
                             $sformatf("got status %0d count %0d col %0d row %0d",
                                       st, cnt, col, row));
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [PIX_W-1:0]   pixel_col;
    logic [PIX_W-1:0]   pixel_row;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         point_status;
    logic [LIMIT_W-1:0] escape_count;
    logic [PIX_W-1:0]   out_col;
    logic [PIX_W-1:0]   out_row;

    pixel_ledger ledger = new();
    int          burst_left = 0;
    int          idle_cycles = 0;

    mandelbrot_escape_time_unit i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stall pattern, changes its density every so often
    initial
    begin
        int stall_pct;
        int span;
        out_stall <= 1'b0;
        forever
        begin
            stall_pct = 25 * $urandom_range(0, 3);
            span = $urandom_range(8, 200);
            repeat (span)
            begin
                @(negedge clk);
                out_stall <= (int'($urandom_range(0, 99)) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                ledger.check_pixel(point_status, escape_count, out_col, out_row);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_register(cfg_reg_t idx, logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        ledger.set_register(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_window(logic [31:0] step, logic [31:0] re0, logic [31:0] im0,
                              logic [31:0] limit);
        write_register(REG_STEP_SIZE, step);
        write_register(REG_ORIGIN_RE, re0);
        write_register(REG_ORIGIN_IM, im0);
        write_register(REG_ITER_LIMIT, limit);
    endtask

    // sender works in bursts with random gaps between them
    task automatic drive_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_pixel(col, row);
    endtask

    task automatic run_pixels(int n, int col_lo, int col_hi, int row_lo, int row_hi);
        for (int k = 0; k < n; k++)
            drive_pixel(PIX_W'($urandom_range(col_hi, col_lo)),
                        PIX_W'($urandom_range(row_hi, row_lo)));
    endtask

    // wait until every item has come back, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int re_pick;
        int im_pick;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        pixel_col <= '0;
        pixel_row <= '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset window: corners, bit patterns, the set's centre and its left tip
        drive_pixel(0, 0);
        drive_pixel(1023, 1023);
        drive_pixel(0, 1023);
        drive_pixel(1023, 0);
        drive_pixel(550, 357);
        drive_pixel(0, 357);
        drive_pixel(341, 682);
        drive_pixel(682, 341);
        drive_pixel(10'h155, 10'h2AA);
        drive_pixel(10'h2AA, 10'h155);
        drive_pixel(512, 512);
        drive_pixel(1022, 2);
        run_pixels(700, 0, 1023, 0, 1023);
        settle();

        // limit of one, then limit of zero
        set_window(976129, -536870912, -348966093, 1);
        run_pixels(30, 0, 1023, 0, 1023);
        settle();
        set_window(976129, -536870912, -348966093, 0);
        run_pixels(30, 0, 1023, 0, 1023);
        settle();

        // zero step: every pixel lands on the same point
        set_window(0, 0, 0, 20);
        drive_pixel(0, 0);
        drive_pixel(1023, 1023);
        drive_pixel(512, 512);
        settle();
        set_window(0, 536870912, -536870912, 20);
        drive_pixel(0, 0);
        drive_pixel(1023, 0);
        drive_pixel(7, 1023);
        settle();

        // window edge on the real axis falls at column 512
        set_window(1, 536870912 - 512, -536870912, 30);
        run_pixels(60, 500, 525, 0, 1023);
        settle();

        // largest step and most negative origins
        set_window(32'h1FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 50);
        run_pixels(60, 0, 7, 0, 7);
        settle();

        // largest limit on an integer grid, only one point inside
        set_window(268435456, -536870912, -536870912, 65535);
        drive_pixel(2, 2);
        drive_pixel(4, 4);
        drive_pixel(0, 0);
        drive_pixel(3, 1);
        drive_pixel(5, 0);
        drive_pixel(1023, 1023);
        settle();

        repeat (4)
        begin
            re_pick = $urandom_range(0, 805306368) - 671088640;
            im_pick = $urandom_range(0, 671088640) - 335544320;
            set_window($urandom_range(1 << 15, 1 << 20), re_pick, im_pick,
                       $urandom_range(2, 150));
            run_pixels(220, 0, 1023, 0, 1023);
            settle();
        end

        if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/met_pkg.sv
hdl/met_cfg.sv
hdl/met_cell.sv
hdl/mandelbrot_escape_time_unit.sv
verif/mandelbrot_escape_time_unit_tb.sv
